@@ design/assert_macros.svh @@
// Assertion macros for the RTL of the matrix unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ design/m4v4_pkg.sv @@
// Types and operation codes of the 4x4 matrix / 4-vector unit.
package m4v4_pkg;

	localparam int unsigned FIELD_W = 32;

	localparam logic [2:0] FUNC_WRITE = 3'd0;
	localparam logic [2:0] FUNC_MUL   = 3'd1;
	localparam logic [2:0] FUNC_ADD   = 3'd2;
	localparam logic [2:0] FUNC_SUB   = 3'd3;
	localparam logic [2:0] FUNC_VEC   = 3'd4;

	typedef struct packed {
		logic [2:0]                 func;
		logic                       matrix_sel;
		logic [1:0]                 row;
		logic [1:0]                 col;
		logic signed [FIELD_W-1:0]  value;
		logic signed [FIELD_W-1:0]  vec_x;
		logic signed [FIELD_W-1:0]  vec_y;
		logic signed [FIELD_W-1:0]  vec_z;
		logic signed [FIELD_W-1:0]  vec_w;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                 out_row;
		logic [1:0]                 out_col;
		logic signed [FIELD_W-1:0]  out_value;
		logic                       last;
	} res_t;

endpackage

@@ design/matrix4_vector4_math_unit_top.sv @@
// Top level of the 4x4 matrix / 4-vector unit: storage, sequencer and shared MAC datapath.
// Timing: a write takes effect at the accepting edge; busy stays low. Other commands pass
// operand fetch, multiply/add, accumulate and the saturating output register in order.
// Throughput: one multiplier/adder, one term a cycle; a multiply walks 64 terms, add and
// subtract 16, a vector 16 (4 elements x 4 terms). No command is taken while busy.
// Results: one per cycle for add/subtract; one per dot product for multiply and vector.
// Reset (arst_n low) clears both matrices to zero and idles; the receiver cannot stall.
`include "assert_macros.svh"

module matrix4_vector4_math_unit_top
	import m4v4_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  cmd_t  cmd,
	output logic  busy,
	output logic  strobe,
	output res_t  result
);

	localparam int VW = VALUE_WIDTH;
	localparam int TW = 2 * VW;      // product / term width
	localparam int AW = TW + 2;      // accumulator: four terms
	localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (VW - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	// ---------------------------------------------------------------
	// Matrix storage, row-major, element index = {row, col}
	// ---------------------------------------------------------------
	logic signed [VW-1:0] mat_a_q [16];
	logic signed [VW-1:0] mat_b_q [16];
	logic signed [VW-1:0] vec_q   [4];

	logic accept;
	logic run_req;
	assign accept  = start && !busy;
	assign run_req = (cmd.func == FUNC_MUL) || (cmd.func == FUNC_ADD) ||
	                 (cmd.func == FUNC_SUB) || (cmd.func == FUNC_VEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_a_q[i] <= '0;
				mat_b_q[i] <= '0;
			end
		end else if (accept && cmd.func == FUNC_WRITE) begin
			if (cmd.matrix_sel)
				mat_b_q[{cmd.row, cmd.col}] <= cmd.value[VW-1:0];
			else
				mat_a_q[{cmd.row, cmd.col}] <= cmd.value[VW-1:0];
		end
	end

	// vector operands, held for the run
	always_ff @(posedge clk) begin
		if (accept && cmd.func == FUNC_VEC) begin
			vec_q[0] <= cmd.vec_x[VW-1:0];
			vec_q[1] <= cmd.vec_y[VW-1:0];
			vec_q[2] <= cmd.vec_z[VW-1:0];
			vec_q[3] <= cmd.vec_w[VW-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Sequencer: walks elements and, for dot products, the four terms
	// ---------------------------------------------------------------
	state_t     state_q;
	logic [2:0] op_q;
	logic [3:0] elem_q;
	logic [1:0] k_q;
	logic       busy_q;
	logic       strobe_q;
	res_t       result_q;

	logic       dot_op;
	logic       last_term;
	logic       last_elem;
	logic [3:0] addr_a;
	logic [3:0] addr_b;

	assign dot_op    = (op_q == FUNC_MUL) || (op_q == FUNC_VEC);
	assign last_term = !dot_op || (k_q == 2'd3);
	assign last_elem = (op_q == FUNC_VEC) ? (elem_q == 4'd3) : (elem_q == 4'd15);
	assign addr_a    = dot_op ? {elem_q[3:2], k_q} : elem_q;
	assign addr_b    = dot_op ? {k_q, elem_q[1:0]} : elem_q;

	// pipeline tags
	logic       vld_s1, vld_s2, res_vld_s3;
	logic       first_s1, first_s2;
	logic       lterm_s1, lterm_s2;
	logic       lres_s1, lres_s2, lres_s3;
	logic [3:0] elem_s1, elem_s2, elem_s3;

	// pipeline data
	logic signed [VW-1:0] opa_s1, opb_s1;
	logic signed [TW-1:0] term_s2;
	logic signed [AW-1:0] acc_q;

	logic signed [TW-1:0] prod;
	logic signed [TW-1:0] term_nxt;
	logic signed [AW-1:0] sat_src;
	logic signed [VW-1:0] sat_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= FUNC_WRITE;
			elem_q     <= '0;
			k_q        <= '0;
			busy_q     <= 1'b0;
			strobe_q   <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			res_vld_s3 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && run_req) begin
						state_q <= ST_RUN;
						op_q    <= cmd.func;
						elem_q  <= '0;
						k_q     <= '0;
						busy_q  <= 1'b1;
					end
				end
				ST_RUN: begin
					if (last_term) begin
						k_q    <= '0;
						elem_q <= elem_q + 4'd1;
						if (last_elem)
							state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			vld_s1     <= (state_q == ST_RUN);
			vld_s2     <= vld_s1;
			res_vld_s3 <= vld_s2 && lterm_s2;
			strobe_q   <= res_vld_s3;
			// drop busy as the final beat enters the output register
			if (res_vld_s3 && lres_s3)
				busy_q <= 1'b0;
		end
	end

	// stage 1: operand fetch
	always_ff @(posedge clk) begin
		opa_s1   <= (op_q == FUNC_VEC) ? vec_q[k_q] : mat_a_q[addr_a];
		opb_s1   <= mat_b_q[addr_b];
		first_s1 <= !dot_op || (k_q == 2'd0);
		lterm_s1 <= last_term;
		lres_s1  <= last_term && last_elem;
		elem_s1  <= elem_q;
	end

	// stage 2: shared multiplier / adder
	assign prod = TW'(opa_s1) * TW'(opb_s1);

	always_comb begin
		case (op_q)
			FUNC_ADD: term_nxt = TW'(opa_s1) + TW'(opb_s1);
			FUNC_SUB: term_nxt = TW'(opa_s1) - TW'(opb_s1);
			default:  term_nxt = prod >>> FRAC_BITS;
		endcase
	end

	always_ff @(posedge clk) begin
		term_s2  <= term_nxt;
		first_s2 <= first_s1;
		lterm_s2 <= lterm_s1;
		lres_s2  <= lres_s1;
		elem_s2  <= elem_s1;
	end

	// stage 3: accumulate
	always_ff @(posedge clk) begin
		if (vld_s2)
			acc_q <= first_s2 ? AW'(term_s2) : acc_q + AW'(term_s2);
		lres_s3 <= lres_s2;
		elem_s3 <= elem_s2;
	end

	// stage 4: saturate into the output register
	assign sat_src = (acc_q > SAT_HI) ? SAT_HI : ((acc_q < SAT_LO) ? SAT_LO : acc_q);
	assign sat_val = sat_src[VW-1:0];

	always_ff @(posedge clk) begin
		if (res_vld_s3) begin
			result_q.out_row   <= elem_s3[3:2];
			result_q.out_col   <= elem_s3[1:0];
			result_q.out_value <= FIELD_W'(sat_val);
			result_q.last      <= lres_s3;
		end
	end

	assign busy   = busy_q;
	assign strobe = strobe_q;
	assign result = result_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`ASSERT_PROP(a_last_frees, clk, arst_n, strobe && result.last |-> !busy, "busy after last beat")
	`ASSERT_PROP(a_mid_busy, clk, arst_n, strobe && !result.last |-> busy, "idle mid run")
	`ASSERT_PROP(a_run_starts, clk, arst_n, accept && run_req |=> busy, "run not started")
	`ASSERT_NEVER(a_idle_empty, clk, arst_n, !busy && (vld_s1 || vld_s2 || res_vld_s3),
		"pipeline active while idle")

endmodule

@@ bench/m4v4_result_checker.sv @@
// Checker for the matrix unit: predicts each result beat from accepted commands and compares.
`timescale 1ns / 100ps

module m4v4_result_checker
	import m4v4_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  busy,
	input  cmd_t  cmd,
	input  logic  strobe,
	input  res_t  result,
	output int    errors,
	output int    pending,
	output int    beats_checked
);

	localparam longint ELEM_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
	localparam longint ELEM_MIN = -ELEM_MAX - 1;

	// shadow copies of both matrices, row-major
	longint a_elems [16];
	longint b_elems [16];
	res_t   expected_beats [$];
	int     mismatch_n = 0;
	int     beat_n     = 0;

	// low VALUE_WIDTH bits as two's complement
	function automatic longint to_elem(input logic [FIELD_W-1:0] raw);
		longint t;
		t = raw;
		t = t <<< (64 - VALUE_WIDTH);
		return t >>> (64 - VALUE_WIDTH);
	endfunction

	// exact product, then arithmetic shift (truncates toward minus infinity)
	function automatic longint fx_mul(input longint x, input longint y);
		return (x * y) >>> FRAC_BITS;
	endfunction

	task automatic queue_beat(input int r, input int c, input longint acc, input logic is_last);
		res_t beat;
		longint clamped;
		clamped = acc;
		if (clamped > ELEM_MAX)
			clamped = ELEM_MAX;
		else if (clamped < ELEM_MIN)
			clamped = ELEM_MIN;
		beat.out_row   = 2'(r);
		beat.out_col   = 2'(c);
		beat.out_value = FIELD_W'(clamped);
		beat.last      = is_last;
		expected_beats.push_back(beat);
	endtask

	task automatic predict(input cmd_t c);
		longint acc;
		longint vec [4];
		int     idx;
		case (c.func)
			FUNC_WRITE: begin
				idx = int'({c.row, c.col});
				if (c.matrix_sel)
					b_elems[idx] = to_elem(c.value);
				else
					a_elems[idx] = to_elem(c.value);
			end
			FUNC_MUL, FUNC_ADD, FUNC_SUB: begin
				for (int i = 0; i < 4; i++) begin
					for (int j = 0; j < 4; j++) begin
						idx = i * 4 + j;
						if (c.func == FUNC_MUL) begin
							acc = 0;
							for (int k = 0; k < 4; k++)
								acc += fx_mul(a_elems[i * 4 + k], b_elems[k * 4 + j]);
						end else if (c.func == FUNC_ADD) begin
							acc = a_elems[idx] + b_elems[idx];
						end else begin
							acc = a_elems[idx] - b_elems[idx];
						end
						queue_beat(i, j, acc, idx == 15);
					end
				end
			end
			FUNC_VEC: begin
				vec[0] = to_elem(c.vec_x);
				vec[1] = to_elem(c.vec_y);
				vec[2] = to_elem(c.vec_z);
				vec[3] = to_elem(c.vec_w);
				for (int j = 0; j < 4; j++) begin
					acc = 0;
					for (int k = 0; k < 4; k++)
						acc += fx_mul(vec[k], b_elems[k * 4 + j]);
					queue_beat(0, j, acc, j == 3);
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_beat(input res_t got);
		res_t want;
		beat_n++;
		if (expected_beats.size() == 0) begin
			mismatch_n++;
			if (mismatch_n <= 10)
				$display("%0t: unexpected beat row=%0d col=%0d value=%h last=%b", $realtime,
					got.out_row, got.out_col, got.out_value, got.last);
		end else begin
			want = expected_beats.pop_front();
			if (got !== want) begin
				mismatch_n++;
				if (mismatch_n <= 10)
					$display("%0t: exp r=%0d c=%0d v=%h l=%b, got r=%0d c=%0d v=%h l=%b",
						$realtime, want.out_row, want.out_col, want.out_value, want.last,
						got.out_row, got.out_col, got.out_value, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 16; n++) begin
				a_elems[n] = 0;
				b_elems[n] = 0;
			end
			expected_beats.delete();
			mismatch_n = 0;
			beat_n = 0;
			errors <= 0;
			pending <= 0;
			beats_checked <= 0;
		end else begin
			// beats of an earlier command come ahead of a command taken at the same edge
			if (strobe)
				check_beat(result);
			if (start && !busy)
				predict(cmd);
			errors <= mismatch_n;
			pending <= expected_beats.size();
			beats_checked <= beat_n;
		end
	end

endmodule

@@ bench/matrix4_vector4_math_unit_top_tb.sv @@
// Testbench top for the matrix unit: drives commands with random gaps and gives the verdict.
`timescale 1ns / 100ps

module matrix4_vector4_math_unit_top_tb;
	import m4v4_pkg::*;

	localparam int VALUE_WIDTH  = 32;
	localparam int FRAC_BITS    = 16;
	// slowest command is a multiply; all 220 commands, even with long gaps, fit easily
	localparam int CYCLE_LIMIT  = 400000;
	// a multiply takes longest to show its last beat after acceptance
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 198;
	localparam int MAX_GAP      = 60;

	// codes the block must ignore
	localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
	localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

	// Q16.16 corner values
	localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;
	localparam logic [31:0] Q_LSB  = 32'h0000_0001;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic strobe;
	res_t result;

	int errors;
	int pending;
	int beats_checked;

	int cycle_count = 0;
	int idle_pct    = 0;   // chance, per cycle, that the sender sits idle
	int n_writes    = 0;
	int n_mat_ops   = 0;
	int n_vec_ops   = 0;
	int n_ignored   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	matrix4_vector4_math_unit_top #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	m4v4_result_checker #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.strobe        (strobe),
		.result        (result),
		.errors        (errors),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	// watchdog: a hung handshake or a missing beat ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// every field random; callers overwrite the ones the function uses,
	// so unused fields always carry noise
	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.func       = 3'($urandom);
		c.matrix_sel = 1'($urandom);
		c.row        = 2'($urandom);
		c.col        = 2'($urandom);
		c.value      = $urandom;
		c.vec_x      = $urandom;
		c.vec_y      = $urandom;
		c.vec_z      = $urandom;
		c.vec_w      = $urandom;
		return c;
	endfunction

	function automatic cmd_t write_cmd(input logic sel, input logic [1:0] r, input logic [1:0] cl,
			input logic [31:0] v);
		cmd_t c;
		c            = noise_cmd();
		c.func       = FUNC_WRITE;
		c.matrix_sel = sel;
		c.row        = r;
		c.col        = cl;
		c.value      = v;
		return c;
	endfunction

	function automatic cmd_t op_cmd(input logic [2:0] f);
		cmd_t c;
		c      = noise_cmd();
		c.func = f;
		return c;
	endfunction

	function automatic cmd_t vec_cmd(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] w);
		cmd_t c;
		c       = noise_cmd();
		c.func  = FUNC_VEC;
		c.vec_x = x;
		c.vec_y = y;
		c.vec_z = z;
		c.vec_w = w;
		return c;
	endfunction

	// Q16.16 operand: some modest magnitudes so products stay in range,
	// plus corners and full-range noise to hit saturation
	function automatic logic [31:0] rand_q();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4, 5: return {{12{raw[19]}}, raw[19:0]};
			default: return raw;
		endcase
	endfunction

	// Present one command and hold it until the block takes it, then maybe idle.
	// start is left high when no gap follows, so back-to-back commands never
	// drop and raise it in the same step.
	task automatic issue_cmd(input cmd_t c);
		int gap;
		cmd   <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		case (c.func)
			FUNC_WRITE: n_writes++;
			FUNC_MUL, FUNC_ADD, FUNC_SUB: n_mat_ops++;
			FUNC_VEC: n_vec_ops++;
			default: n_ignored++;
		endcase
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			cmd   <= noise_cmd();   // junk on the bus while start is low
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// both matrices are zero straight out of reset
		issue_cmd(op_cmd(FUNC_MUL));
		issue_cmd(vec_cmd(Q_MAX, Q_MIN, Q_NEG1, Q_ONE));

		// A: extremes in row 0, -1 at the far corner, 1.0 inside
		issue_cmd(write_cmd(1'b0, 2'd0, 2'd0, Q_MAX));
		issue_cmd(write_cmd(1'b0, 2'd0, 2'd1, Q_MIN));
		issue_cmd(write_cmd(1'b0, 2'd3, 2'd3, Q_NEG1));
		issue_cmd(write_cmd(1'b0, 2'd2, 2'd1, Q_ONE));

		// B: max*max + min*min overflows the dot product high;
		// min * -1 checks sign of the shifted product; -1 * lsb truncates to -1
		issue_cmd(write_cmd(1'b1, 2'd0, 2'd0, Q_MAX));
		issue_cmd(write_cmd(1'b1, 2'd1, 2'd0, Q_MIN));
		issue_cmd(write_cmd(1'b1, 2'd3, 2'd3, Q_MIN));
		issue_cmd(write_cmd(1'b1, 2'd1, 2'd2, Q_NEG1));
		issue_cmd(write_cmd(1'b1, 2'd3, 2'd0, Q_LSB));
		issue_cmd(write_cmd(1'b1, 2'd0, 2'd1, Q_MAX));
		issue_cmd(write_cmd(1'b1, 2'd2, 2'd2, Q_MIN));

		// add saturates high at (0,0); subtract saturates low at (0,1)
		issue_cmd(op_cmd(FUNC_ADD));
		issue_cmd(op_cmd(FUNC_SUB));
		issue_cmd(op_cmd(FUNC_MUL));
		issue_cmd(vec_cmd(Q_MAX, Q_MIN, Q_NEG1, Q_ONE));
		issue_cmd(vec_cmd(Q_MIN, Q_MIN, Q_MIN, Q_MIN));

		// ignored codes must not touch state or emit anything
		issue_cmd(op_cmd(FUNC_UNUSED_LO));
		issue_cmd(op_cmd(3'd6));
		issue_cmd(op_cmd(FUNC_UNUSED_HI));
		issue_cmd(op_cmd(FUNC_ADD));

		// ---- random part, in idle phases: none, heavy, none, light ----
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ((n * 4) / RANDOM_ITEMS)
				0: idle_pct = 0;
				1: idle_pct = 87;
				2: idle_pct = 0;
				default: idle_pct = 19;
			endcase
			pick = $urandom_range(99);
			if (pick < 55)
				issue_cmd(write_cmd(1'($urandom), 2'($urandom), 2'($urandom), rand_q()));
			else if (pick < 68)
				issue_cmd(op_cmd(FUNC_MUL));
			else if (pick < 76)
				issue_cmd(op_cmd(FUNC_ADD));
			else if (pick < 84)
				issue_cmd(op_cmd(FUNC_SUB));
			else if (pick < 96)
				issue_cmd(vec_cmd(rand_q(), rand_q(), rand_q(), rand_q()));
			else
				issue_cmd(op_cmd(3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO))));
		end

		// ---- drain ----
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// stray beats after the last expected one still get flagged
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d writes, %0d matrix ops, %0d vector transforms, %0d ignored codes",
			n_writes, n_mat_ops, n_vec_ops, n_ignored);
		$display("Compared %0d result beats in %0d cycles; %0d mismatches",
			beats_checked, cycle_count, errors);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
